[sv/fpgs_pkg.sv]
// Shared types, constants, rule tables and helpers for the fuzzy PID gain scheduler.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package fpgs_pkg;

  localparam int unsigned N_ERR      = 9;
  localparam int unsigned N_RATE     = 3;
  localparam int unsigned N_RULES    = 27;
  localparam int unsigned DIV_STEPS  = 15;
  localparam int unsigned FIFO_DEPTH = 32;
  localparam int unsigned FIFO_AW    = 5;
  localparam logic [15:0] ONE_Q15    = 16'd32768;

  typedef enum logic [2:0] {
    CFG_ERROR_POINTS_LOW  = 3'd0,
    CFG_ERROR_POINTS_HIGH = 3'd1,
    CFG_LAST_RATE_POINTS  = 3'd2,
    CFG_KP_LEVELS         = 3'd3,
    CFG_KI_LEVELS         = 3'd4,
    CFG_KD_LEVELS         = 3'd5
  } cfg_index_e;

  typedef struct packed {
    logic signed [15:0] error_rate;
    logic signed [15:0] error_sample;
  } in_item_t;

  typedef struct packed {
    logic [9:0] gain_d;
    logic [9:0] gain_i;
    logic [9:0] gain_p;
  } out_item_t;

  typedef struct packed {
    logic [59:0] kp;
    logic [59:0] ki;
    logic [59:0] kd;
  } levels_t;

  // Set indexes of the two active memberships of each input.
  typedef struct packed {
    logic [3:0] ej_a;
    logic [3:0] ej_b;
    logic [1:0] rj_a;
    logic [1:0] rj_b;
  } sel_t;

  // Classified item: set indexes plus the dividend and divisor of each segment.
  typedef struct packed {
    sel_t        sel;
    logic [15:0] e_off;
    logic [15:0] e_div;
    logic [15:0] r_off;
    logic [15:0] r_div;
  } cls_t;

  localparam logic [2:0] PI_LEVEL [N_RULES] = '{
    3'd0, 3'd1, 3'd2, 3'd3, 3'd5, 3'd3, 3'd2, 3'd1, 3'd0,
    3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1,
    3'd0, 3'd1, 3'd2, 3'd3, 3'd5, 3'd3, 3'd2, 3'd1, 3'd0
  };

  // Derivative levels are numbered from one; this table holds the field number.
  localparam logic [2:0] D_INDEX [N_RULES] = '{
    3'd5, 3'd4, 3'd3, 3'd2, 3'd0, 3'd2, 3'd3, 3'd4, 3'd5,
    3'd4, 3'd3, 3'd2, 3'd1, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
    3'd5, 3'd4, 3'd3, 3'd2, 3'd0, 3'd2, 3'd3, 3'd4, 3'd5
  };

  function automatic logic [4:0] rule_idx(logic [1:0] r, logic [3:0] j);
    logic [4:0] base;
    base = {3'b000, r} * 5'd9;
    return base + {1'b0, j};
  endfunction

  function automatic logic [9:0] pick_level(logic [59:0] lv, logic [2:0] n);
    logic [9:0] res;
    case (n)
      3'd0:    res = lv[9:0];
      3'd1:    res = lv[19:10];
      3'd2:    res = lv[29:20];
      3'd3:    res = lv[39:30];
      3'd4:    res = lv[49:40];
      3'd5:    res = lv[59:50];
      default: res = 10'd0;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

[sv/fpgs_front.sv]
// Front end: finds the membership segment of both inputs and registers the result.
// Depends on fpgs_pkg.
`default_nettype none

module fpgs_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  input  fpgs_pkg::in_item_t    data_i,
  input  wire logic [63:0]      pts_low_i,
  input  wire logic [63:0]      pts_high_i,
  input  wire logic [63:0]      pts_last_i,
  output logic                  valid_o,
  output fpgs_pkg::cls_t        cls_o
);
  import fpgs_pkg::*;

  logic signed [15:0] ep [N_ERR];
  logic signed [15:0] rp [N_RATE];
  cls_t cls_d, cls_q;
  logic valid_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ep[i]     = pts_low_i[16*i +: 16];
      ep[i + 4] = pts_high_i[16*i +: 16];
    end
    ep[8] = pts_last_i[15:0];
    for (int i = 0; i < 3; i++) begin
      rp[i] = pts_last_i[16*(i+1) +: 16];
    end
  end

  // Error segment: the lowest segment whose upper breakpoint lies above the sample.
  always_comb begin
    logic [3:0]  k;
    logic        found;
    logic [16:0] off;
    logic [16:0] dif;
    found = 1'b0;
    k     = 4'd0;
    for (int i = N_ERR - 2; i >= 0; i--) begin
      if (data_i.error_sample < ep[i+1]) begin
        found = 1'b1;
        k     = 4'(i);
      end
    end
    off = {data_i.error_sample[15], data_i.error_sample} - {ep[k][15], ep[k]};
    dif = {ep[4'(k + 4'd1)][15], ep[4'(k + 4'd1)]} - {ep[k][15], ep[k]};
    if (data_i.error_sample < ep[0]) begin
      cls_d.sel.ej_a = 4'd0;
      cls_d.sel.ej_b = 4'd0;
      cls_d.e_off    = 16'd0;
      cls_d.e_div    = 16'd1;
    end else if (found) begin
      cls_d.sel.ej_a = k;
      cls_d.sel.ej_b = 4'(k + 4'd1);
      cls_d.e_off    = off[15:0];
      cls_d.e_div    = dif[15:0];
    end else begin
      cls_d.sel.ej_a = 4'(N_ERR - 1);
      cls_d.sel.ej_b = 4'(N_ERR - 1);
      cls_d.e_off    = 16'd0;
      cls_d.e_div    = 16'd1;
    end
  end

  // Rate segment, same rule over three breakpoints.
  always_comb begin
    logic [1:0]  k;
    logic        found;
    logic [16:0] off;
    logic [16:0] dif;
    found = 1'b0;
    k     = 2'd0;
    for (int i = N_RATE - 2; i >= 0; i--) begin
      if (data_i.error_rate < rp[i+1]) begin
        found = 1'b1;
        k     = 2'(i);
      end
    end
    off = {data_i.error_rate[15], data_i.error_rate} - {rp[k][15], rp[k]};
    dif = {rp[2'(k + 2'd1)][15], rp[2'(k + 2'd1)]} - {rp[k][15], rp[k]};
    if (data_i.error_rate < rp[0]) begin
      cls_d.sel.rj_a = 2'd0;
      cls_d.sel.rj_b = 2'd0;
      cls_d.r_off    = 16'd0;
      cls_d.r_div    = 16'd1;
    end else if (found) begin
      cls_d.sel.rj_a = k;
      cls_d.sel.rj_b = 2'(k + 2'd1);
      cls_d.r_off    = off[15:0];
      cls_d.r_div    = dif[15:0];
    end else begin
      cls_d.sel.rj_a = 2'(N_RATE - 1);
      cls_d.sel.rj_b = 2'(N_RATE - 1);
      cls_d.r_off    = 16'd0;
      cls_d.r_div    = 16'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      cls_q <= cls_d;
    end
  end

  assign valid_o = valid_q;
  assign cls_o   = cls_q;

endmodule

`default_nettype wire

[sv/fpgs_div.sv]
// Pipelined restoring divider: one quotient bit per stage, gives off * 2^15 / div.
// Depends on fpgs_pkg; the dividend must be below the divisor.
`default_nettype none

module fpgs_div (
  input  wire logic        clk_i,
  input  wire logic [15:0] off_i,
  input  wire logic [15:0] div_i,
  output logic      [14:0] quo_o
);
  import fpgs_pkg::*;

  logic [15:0] rem_q [DIV_STEPS];
  logic [15:0] den_q [DIV_STEPS];
  logic [14:0] quo_q [DIV_STEPS];

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
    logic [15:0] rem_in;
    logic [15:0] den_in;
    logic [14:0] quo_in;
    logic [16:0] dbl;
    logic        ge;
    logic [16:0] sub;

    if (s == 0) begin : g_first
      assign rem_in = off_i;
      assign den_in = div_i;
      assign quo_in = 15'd0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    assign dbl = {rem_in, 1'b0};
    assign ge  = dbl >= {1'b0, den_in};
    assign sub = dbl - {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      rem_q[s] <= ge ? sub[15:0] : dbl[15:0];
      den_q[s] <= den_in;
      quo_q[s] <= {quo_in[13:0], ge};
    end
  end

  assign quo_o = quo_q[DIV_STEPS-1];

endmodule

`default_nettype wire

[sv/fpgs_back.sv]
// Back end: membership division, rule weighting and rounding into gain codes.
// Depends on fpgs_pkg and fpgs_div.
`default_nettype none

module fpgs_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  input  fpgs_pkg::cls_t        cls_i,
  input  fpgs_pkg::levels_t     levels_i,
  output logic                  valid_o,
  output fpgs_pkg::out_item_t   data_o
);
  import fpgs_pkg::*;

  logic [14:0] ue, ur;
  sel_t        sb_q  [DIV_STEPS];
  logic [DIV_STEPS-1:0] vld_q;

  fpgs_div u_div_err (.clk_i(clk_i), .off_i(cls_i.e_off), .div_i(cls_i.e_div), .quo_o(ue));
  fpgs_div u_div_rate(.clk_i(clk_i), .off_i(cls_i.r_off), .div_i(cls_i.r_div), .quo_o(ur));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[DIV_STEPS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    sb_q[0] <= cls_i.sel;
    for (int s = 1; s < DIV_STEPS; s++) begin
      sb_q[s] <= sb_q[s-1];
    end
  end

  // Stage A: error membership times rule level for the four active rules.
  sel_t        sel;
  logic [15:0] me [2];
  logic [15:0] mr [2];
  logic [25:0] prod_d [3][2][2];
  logic [25:0] prod_q [3][2][2];
  logic [15:0] mra_q [2];
  logic [15:0] mrb_q [2];
  logic        va_q, vb_q, vc_q;

  assign sel   = sb_q[DIV_STEPS-1];
  assign me[0] = ONE_Q15 - {1'b0, ue};
  assign me[1] = {1'b0, ue};
  assign mr[0] = ONE_Q15 - {1'b0, ur};
  assign mr[1] = {1'b0, ur};

  always_comb begin
    logic [1:0]  rj;
    logic [3:0]  ej;
    logic [4:0]  ri;
    logic [9:0]  lv;
    for (int r = 0; r < 2; r++) begin
      for (int e = 0; e < 2; e++) begin
        rj = (r == 0) ? sel.rj_a : sel.rj_b;
        ej = (e == 0) ? sel.ej_a : sel.ej_b;
        ri = rule_idx(rj, ej);
        lv = pick_level(levels_i.kp, PI_LEVEL[ri]);
        prod_d[0][r][e] = {10'd0, me[e]} * {16'd0, lv};
        lv = pick_level(levels_i.ki, PI_LEVEL[ri]);
        prod_d[1][r][e] = {10'd0, me[e]} * {16'd0, lv};
        lv = pick_level(levels_i.kd, D_INDEX[ri]);
        prod_d[2][r][e] = {10'd0, me[e]} * {16'd0, lv};
      end
    end
  end

  // Stage B: sum over the error sets; stage C: times the rate membership.
  logic [26:0] esum_q [3][2];
  logic [42:0] w_q    [3][2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      va_q <= vld_q[DIV_STEPS-1];
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= prod_d;
    mra_q[0] <= mr[0];
    mra_q[1] <= mr[1];
    mrb_q    <= mra_q;
    for (int g = 0; g < 3; g++) begin
      for (int r = 0; r < 2; r++) begin
        esum_q[g][r] <= {1'b0, prod_q[g][r][0]} + {1'b0, prod_q[g][r][1]};
        w_q[g][r]    <= {27'd0, mrb_q[r]} * {16'd0, esum_q[g][r]};
      end
    end
  end

  // Final sum and round half up; the fifo captures this directly.
  logic [43:0] tot [3];

  always_comb begin
    for (int g = 0; g < 3; g++) begin
      tot[g] = {1'b0, w_q[g][0]} + {1'b0, w_q[g][1]} + (44'd1 << 29);
    end
  end

  assign valid_o       = vc_q;
  assign data_o.gain_p = tot[0][39:30];
  assign data_o.gain_i = tot[1][39:30];
  assign data_o.gain_d = tot[2][39:30];

endmodule

`default_nettype wire

[sv/fpgs_fifo.sv]
// Result queue that decouples the arithmetic pipeline from the consumer.
// The oldest request sits in a registered head stage in front of the storage array.
// Depends on fpgs_pkg.
`default_nettype none

module fpgs_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  fpgs_pkg::out_item_t   data_i,
  input  wire logic             pop_i,
  output fpgs_pkg::out_item_t   data_o,
  output logic                  empty_o
);
  import fpgs_pkg::*;

  out_item_t           mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  wr_q, rd_q;
  logic [FIFO_AW:0]    cnt_q;
  out_item_t           head_q;
  logic                head_vld_q;
  logic                do_pop;
  logic                head_free;
  logic                load;
  logic                bypass;
  logic                store;

  // The head is refilled from the array when it has entries, otherwise an
  // incoming request goes straight into the head.
  assign empty_o   = !head_vld_q;
  assign do_pop    = pop_i && head_vld_q;
  assign head_free = !head_vld_q || do_pop;
  assign load      = head_free && (cnt_q != '0);
  assign bypass    = head_free && (cnt_q == '0) && push_i;
  assign store     = push_i && !bypass;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q       <= '0;
      rd_q       <= '0;
      cnt_q      <= '0;
      head_vld_q <= 1'b0;
    end else begin
      if (store) begin
        wr_q <= wr_q + 1'b1;
      end
      if (load) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (FIFO_AW+1)'(store) - (FIFO_AW+1)'(load);
      if (load || bypass) begin
        head_vld_q <= 1'b1;
      end else if (do_pop) begin
        head_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (store) begin
      mem[wr_q] <= data_i;
    end
    if (load) begin
      head_q <= mem[rd_q];
    end else if (bypass) begin
      head_q <= data_i;
    end
  end

  assign data_o = head_q;

endmodule

`default_nettype wire

[sv/fuzzy_pid_gain_scheduler.sv]
// Top level of the fuzzy PID gain scheduler: configuration registers, front end,
// back end and result queue. Depends on fpgs_pkg, fpgs_front, fpgs_back, fpgs_fifo.
//
// Use: an input request (error_sample, error_rate) is taken at a rising edge with
// push high and full low. The result request (gain_p, gain_i, gain_d) sits on
// out_data_o while empty is low and is taken at an edge with pop high.
// Configuration writes use cfg_valid_i/cfg_ready_o; ready is always high and
// indexes beyond the six registers are dropped. Write only while idle.
// One input can be taken every cycle while full is low; behind the front end, the
// 15-stage divider pipeline and the three weighting stages never stall.
// The 32-entry result queue bounds the number of outstanding requests: full rises
// when 32 requests are accepted and not yet popped, so a stalled receiver
// backs pressure up to the input side without losing anything in flight.
// Reset: all configuration registers clear to zero, the queue empties and no
// request is in flight.
`default_nettype none

module fuzzy_pid_gain_scheduler (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push,
  output logic                  full,
  input  fpgs_pkg::in_item_t    in_data_i,
  output logic                  empty,
  input  wire logic             pop,
  output fpgs_pkg::out_item_t   out_data_o,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [2:0]       cfg_index_i,
  input  wire logic [63:0]      cfg_data_i
);
  import fpgs_pkg::*;

  logic [63:0] pts_low_q, pts_high_q, pts_last_q;
  levels_t     levels_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pts_low_q  <= '0;
      pts_high_q <= '0;
      pts_last_q <= '0;
      levels_q   <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_ERROR_POINTS_LOW:  pts_low_q   <= cfg_data_i;
        CFG_ERROR_POINTS_HIGH: pts_high_q  <= cfg_data_i;
        CFG_LAST_RATE_POINTS:  pts_last_q  <= cfg_data_i;
        CFG_KP_LEVELS:         levels_q.kp <= cfg_data_i[59:0];
        CFG_KI_LEVELS:         levels_q.ki <= cfg_data_i[59:0];
        CFG_KD_LEVELS:         levels_q.kd <= cfg_data_i[59:0];
        default: ;
      endcase
    end
  end

  // Outstanding requests: accepted but not yet popped. This count reserves a
  // queue slot for every request still in the pipeline.
  logic [FIFO_AW:0] out_cnt_q;
  logic             accept, take;

  assign full   = (out_cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign accept = push && !full;
  assign take   = pop && !empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_cnt_q <= '0;
    end else begin
      out_cnt_q <= out_cnt_q + (FIFO_AW+1)'(accept) - (FIFO_AW+1)'(take);
    end
  end

  logic      f_valid;
  cls_t      f_cls;
  logic      b_valid;
  out_item_t b_data;

  fpgs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (accept),
    .data_i     (in_data_i),
    .pts_low_i  (pts_low_q),
    .pts_high_i (pts_high_q),
    .pts_last_i (pts_last_q),
    .valid_o    (f_valid),
    .cls_o      (f_cls)
  );

  fpgs_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (f_valid),
    .cls_i    (f_cls),
    .levels_i (levels_q),
    .valid_o  (b_valid),
    .data_o   (b_data)
  );

  fpgs_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (b_valid),
    .data_i  (b_data),
    .pop_i   (pop),
    .data_o  (out_data_o),
    .empty_o (empty)
  );

endmodule

`default_nettype wire

[sv/fpgs_checker.sv]
// Port-level checker for the fuzzy PID gain scheduler, bound to the top level.
// Depends on fpgs_pkg and fuzzy_pid_gain_scheduler.
`default_nettype none

module fpgs_checker (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           full,
  input  wire logic           empty,
  input  wire logic           pop,
  input  fpgs_pkg::out_item_t out_data_o
);
  import fpgs_pkg::*;

  // Leaving reset, nothing may be waiting.
  a_reset_empty: assert property (@(posedge clk_i) $rose(rst_ni) |-> empty && !full)
    else $error("queue not empty after reset");

  // The pipeline holds fewer requests than the queue depth, so full implies results wait.
  a_full_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni) full |-> !empty)
    else $error("full asserted with no result waiting");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty)
    else $error("waiting result vanished");

  a_result_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> $stable(out_data_o))
    else $error("waiting result changed");

endmodule

bind fuzzy_pid_gain_scheduler fpgs_checker u_fpgs_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .out_data_o (out_data_o)
);

`default_nettype wire

[verif/fuzzy_pid_gain_scheduler_test.sv]
// Self-checking testbench for the fuzzy PID gain scheduler: a queued driver, a
// popping monitor and a bit-exact gain predictor. Depends on fpgs_pkg and the block.
`default_nettype none

module fuzzy_pid_gain_scheduler_test;
  import fpgs_pkg::*;

  // Rule tables of the scheduler. Rows are rate sets, columns error sets. The
  // derivative table holds level numbers from one to six.
  localparam int PI_RULE [27] = '{
    0, 1, 2, 3, 5, 3, 2, 1, 0,
    1, 2, 3, 4, 5, 4, 3, 2, 1,
    0, 1, 2, 3, 5, 3, 2, 1, 0
  };
  localparam int D_RULE [27] = '{
    6, 5, 4, 3, 1, 3, 4, 5, 6,
    5, 4, 3, 2, 1, 2, 3, 4, 5,
    6, 5, 4, 3, 1, 3, 4, 5, 6
  };
  localparam int LATENCY_CYCLES = 20;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  in_item_t    in_data_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  out_item_t   out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;

  fuzzy_pid_gain_scheduler dut (
    .clk_i, .rst_ni, .push, .full, .in_data_i, .empty, .pop, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #6 clk_i = ~clk_i;

  // Shadow copy of the configuration that the predictor works from.
  logic [63:0] err_lo_reg, err_hi_reg, last_rate_reg;
  logic [59:0] kp_reg, ki_reg, kd_reg;

  in_item_t  sample_queue [$];
  out_item_t gain_queue [$];
  int        n_errors = 0;
  bit        stim_done = 1'b0;

  // Burst and stall control for the two sides.
  int burst_left = 0;
  int gap_left = 0;
  int stall_mode = 0;

  // Triangular memberships of x over n breakpoints, Q1.15 per set.
  function automatic void membership_q15(input int x, input int pts [9], input int n,
                                         output longint mu [9]);
    longint u;
    for (int k = 0; k < 9; k++) mu[k] = 0;
    if (x < pts[0]) begin
      mu[0] = 32768;
      return;
    end
    for (int k = 0; k + 1 < n; k++) begin
      if (x < pts[k + 1]) begin
        u = (longint'(x - pts[k]) * 32768) / longint'(pts[k + 1] - pts[k]);
        mu[k + 1] = u;
        mu[k] = 32768 - u;
        return;
      end
    end
    mu[n - 1] = 32768;
  endfunction

  function automatic out_item_t scheduled_gains(in_item_t s);
    int      ep [9];
    int      rp [9];
    longint  me [9];
    longint  mr [9];
    longint  w;
    longint  sp, si, sd;
    out_item_t g;
    for (int i = 0; i < 9; i++) rp[i] = 0;
    for (int i = 0; i < 4; i++) begin
      ep[i] = int'($signed(err_lo_reg[16*i +: 16]));
      ep[i + 4] = int'($signed(err_hi_reg[16*i +: 16]));
    end
    ep[8] = int'($signed(last_rate_reg[15:0]));
    for (int i = 0; i < 3; i++) rp[i] = int'($signed(last_rate_reg[16*(i+1) +: 16]));
    membership_q15(int'(s.error_sample), ep, 9, me);
    membership_q15(int'(s.error_rate), rp, 3, mr);
    sp = 0; si = 0; sd = 0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 9; j++) begin
        w = mr[i] * me[j];
        sp += w * longint'(kp_reg[10*PI_RULE[i*9+j] +: 10]);
        si += w * longint'(ki_reg[10*PI_RULE[i*9+j] +: 10]);
        sd += w * longint'(kd_reg[10*(D_RULE[i*9+j]-1) +: 10]);
      end
    end
    g.gain_p = 10'((sp + (64'sd1 <<< 29)) >>> 30);
    g.gain_i = 10'((si + (64'sd1 <<< 29)) >>> 30);
    g.gain_d = 10'((sd + (64'sd1 <<< 29)) >>> 30);
    return g;
  endfunction

  // Driver: bursts of requests with random gaps. The predictor runs on acceptance,
  // and the accepted request leaves the pending queue right away, so the head of
  // the queue is always the next request to drive.
  always @(posedge clk_i) begin
    if (push && !full) begin
      gain_queue.push_back(scheduled_gains(in_data_i));
      void'(sample_queue.pop_front());
    end
    if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      push <= 1'b0;
    end else if (sample_queue.size() > 0) begin
      push <= 1'b1;
      in_data_i <= sample_queue[0];
      if (push && !full) begin
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          if ($urandom_range(0, 2) != 0) gap_left <= $urandom_range(0, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end else begin
      push <= 1'b0;
    end
  end

  // Monitor: pops with a stall pattern that changes between modes, one of them
  // never stalling and one stalling long enough to fill the result queue.
  always @(posedge clk_i) begin
    out_item_t exp_g;
    if (pop && !empty) begin
      if (gain_queue.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data_o);
        n_errors++;
      end else begin
        exp_g = gain_queue.pop_front();
        if (exp_g.gain_p !== out_data_o.gain_p) begin
          $display("%0t: gain_p expected %0d actual %0d", $time, exp_g.gain_p,
                   out_data_o.gain_p);
          n_errors++;
        end
        if (exp_g.gain_i !== out_data_o.gain_i) begin
          $display("%0t: gain_i expected %0d actual %0d", $time, exp_g.gain_i,
                   out_data_o.gain_i);
          n_errors++;
        end
        if (exp_g.gain_d !== out_data_o.gain_d) begin
          $display("%0t: gain_d expected %0d actual %0d", $time, exp_g.gain_d,
                   out_data_o.gain_d);
          n_errors++;
        end
      end
    end
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: pop <= 1'b1;
      1: pop <= ($urandom_range(0, 3) != 0);
      2: pop <= ($urandom_range(0, 1) != 0);
      default: pop <= ($urandom_range(0, 59) == 0);
    endcase
  end

  task automatic write_reg(cfg_index_e idx, logic [63:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_ERROR_POINTS_LOW:  err_lo_reg = value;
      CFG_ERROR_POINTS_HIGH: err_hi_reg = value;
      CFG_LAST_RATE_POINTS:  last_rate_reg = value;
      CFG_KP_LEVELS:         kp_reg = value[59:0];
      CFG_KI_LEVELS:         ki_reg = value[59:0];
      CFG_KD_LEVELS:         kd_reg = value[59:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    wait (sample_queue.size() == 0 && !push && gain_queue.size() == 0);
    repeat (LATENCY_CYCLES + 5) @(posedge clk_i);
  endtask

  // Random ascending breakpoints; sometimes deliberately out of order.
  function automatic logic [63:0] pack_points(int pts [4]);
    return {16'(pts[3]), 16'(pts[2]), 16'(pts[1]), 16'(pts[0])};
  endfunction

  task automatic random_setting(bit sorted, bit wide);
    int p [12];
    int t;
    int span;
    span = wide ? 65535 : 2000;
    for (int i = 0; i < 12; i++) p[i] = $urandom_range(0, span) - span / 2;
    if (sorted) begin
      for (int i = 0; i < 12; i++)
        for (int j = i + 1; j < 12; j++)
          if (p[j] < p[i]) begin
            t = p[i]; p[i] = p[j]; p[j] = t;
          end
    end
    write_reg(CFG_ERROR_POINTS_LOW, pack_points('{p[0], p[1], p[2], p[3]}));
    write_reg(CFG_ERROR_POINTS_HIGH, pack_points('{p[4], p[5], p[6], p[7]}));
    write_reg(CFG_LAST_RATE_POINTS, {16'(p[11]), 16'(p[10]), 16'(p[9]), 16'(p[8])});
    write_reg(CFG_KP_LEVELS, {$urandom, $urandom});
    write_reg(CFG_KI_LEVELS, {$urandom, $urandom});
    write_reg(CFG_KD_LEVELS, {$urandom, $urandom});
  endtask

  task automatic queue_sample(int e, int r);
    in_item_t s;
    s.error_sample = 16'(e);
    s.error_rate = 16'(r);
    sample_queue.push_back(s);
  endtask

  initial begin
    err_lo_reg = '0; err_hi_reg = '0; last_rate_reg = '0;
    kp_reg = '0; ki_reg = '0; kd_reg = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Default configuration: all breakpoints at zero, all levels zero.
    queue_sample(-32768, 32767);
    queue_sample(32767, -32768);
    wait_drained();

    // Points from the lowest to the highest value, all-ones P and I levels, graded D
    // levels, then the directed cases: on the end points, on inner points, mid-segment.
    write_reg(CFG_ERROR_POINTS_LOW, {16'hC000, 16'hA000, 16'h9000, 16'h8000});
    write_reg(CFG_ERROR_POINTS_HIGH, {16'h7FFE, 16'h6000, 16'h4000, 16'h0000});
    write_reg(CFG_LAST_RATE_POINTS, {16'h7FFF, 16'h0000, 16'h8000, 16'h7FFF});
    write_reg(CFG_KP_LEVELS, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(CFG_KI_LEVELS, 64'h0FFF_FFFF_FFFF_FFFF);
    write_reg(CFG_KD_LEVELS, {4'h0, 10'd1023, 10'd900, 10'd600, 10'd300, 10'd100, 10'd0});
    queue_sample(-32768, -32768);
    queue_sample(32767, 32767);
    queue_sample(16'h7FFE, 0);
    queue_sample(0, -1);
    queue_sample(-1, 1);
    queue_sample(16'h9000, 16'h4000);
    queue_sample(16'h9001, 16'hC000);
    queue_sample(16'h5555, 16'h2AAA);
    queue_sample(16'hAAAA, 16'hD555);
    queue_sample(100, 32766);
    wait_drained();

    // Descending points: the first segment whose comparisons hold is used.
    write_reg(CFG_ERROR_POINTS_LOW, {16'h1000, 16'h2000, 16'h3000, 16'h4000});
    write_reg(CFG_LAST_RATE_POINTS, {16'h8000, 16'h0100, 16'h0000, 16'h0500});
    for (int i = 0; i < 8; i++) queue_sample(i * 4096 - 8192, i * 8192 - 32768);
    wait_drained();

    // Random phases, alternating narrow and full-range points.
    for (int phase = 0; phase < 7; phase++) begin
      random_setting(phase != 3, phase % 2 == 0);
      for (int i = 0; i < 200; i++) begin
        if ($urandom_range(0, 3) == 0)
          queue_sample($urandom_range(0, 65535), $urandom_range(0, 65535));
        else
          queue_sample($urandom_range(0, 2400) - 1200, $urandom_range(0, 2400) - 1200);
      end
      wait_drained();
    end
    stim_done = 1'b1;

    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog sized well above the slowest run with the receiver mostly stalled.
  initial begin
    #30_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
sv/fpgs_pkg.sv
sv/fpgs_front.sv
sv/fpgs_div.sv
sv/fpgs_back.sv
sv/fpgs_fifo.sv
sv/fuzzy_pid_gain_scheduler.sv
sv/fpgs_checker.sv
verif/fuzzy_pid_gain_scheduler_test.sv
